/* sv/vgmcsp_pkg.sv */
// Shared types and constants for the command stream parser.
`default_nettype none

package vgmcsp_pkg;

   // Command byte codes
   localparam logic [7:0] CMD_REG_WRITE  = 8'h55;
   localparam logic [7:0] CMD_WAIT_N     = 8'h61;
   localparam logic [7:0] CMD_WAIT_NTSC  = 8'h62;
   localparam logic [7:0] CMD_WAIT_PAL   = 8'h63;
   localparam logic [7:0] CMD_END        = 8'h66;
   localparam logic [7:0] CMD_DATA_BLOCK = 8'h67;
   localparam logic [7:0] CMD_SHORT_MASK = 8'hF0;
   localparam logic [7:0] CMD_SHORT_WAIT = 8'h70;
   localparam logic [7:0] SHORT_LEN_MASK = 8'h0F;

   // Fixed wait lengths in samples
   localparam logic [15:0] WAIT_NTSC_SAMPLES = 16'd735;
   localparam logic [15:0] WAIT_PAL_SAMPLES  = 16'd882;

   // Last byte index of the four-byte block size
   localparam logic [1:0] SIZE_LAST_INDEX = 2'd3;

   typedef enum logic [3:0] {
      PH_CMD       = 4'd0,
      PH_WR_ADDR   = 4'd1,
      PH_WR_DATA   = 4'd2,
      PH_WAIT_LO   = 4'd3,
      PH_WAIT_HI   = 4'd4,
      PH_BLK_MARK  = 4'd5,
      PH_BLK_TYPE  = 4'd6,
      PH_BLK_SIZE  = 4'd7,
      PH_BLK_SKIP  = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      EV_WRITE   = 3'd0,
      EV_WAIT    = 3'd1,
      EV_LOOP    = 3'd2,
      EV_END     = 3'd3,
      EV_UNKNOWN = 3'd4,
      EV_TRUNC   = 3'd5
   } event_kind_type;

   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     reg_address;
      logic [7:0]     reg_value;
      logic [15:0]    wait_samples;
   } event_type;

   // Decoder to output buffer: one event beat
   typedef struct packed {
      logic      valid;
      event_type ev;
   } event_beat_type;

endpackage

`default_nettype wire

/* sv/vgmcsp_decoder.sv */
// Parser state registers and combinational command decode.
`default_nettype none

module vgmcsp_decoder (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write_enable,
   input  wire logic                     csr_write_data,
   input  wire logic                     byte_accept,
   input  wire logic [7:0]               stream_byte,
   input  wire logic                     last_byte,
   output vgmcsp_pkg::event_beat_type    result
);

   logic                  loop_enabled_ff;
   vgmcsp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]            held_address_ff, held_address_in;
   logic [7:0]            wait_low_ff, wait_low_in;
   logic [31:0]           skip_ff, skip_in;
   logic [1:0]            size_index_ff, size_index_in;
   logic                  stopped_ff, stopped_in;

   logic [31:0]           size_merged;
   logic [31:0]           skip_dec;
   logic [15:0]           wait_full;

   // Hold the loop configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         loop_enabled_ff <= 1'b0;
      end else if (csr_write_enable) begin
         loop_enabled_ff <= csr_write_data;
      end
   end

   // Advance the parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= vgmcsp_pkg::PH_CMD;
         held_address_ff <= 8'd0;
         wait_low_ff     <= 8'd0;
         skip_ff         <= 32'd0;
         size_index_ff   <= 2'd0;
         stopped_ff      <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         held_address_ff <= held_address_in;
         wait_low_ff     <= wait_low_in;
         skip_ff         <= skip_in;
         size_index_ff   <= size_index_in;
         stopped_ff      <= stopped_in;
      end
   end

   assign size_merged = skip_ff | ({24'd0, stream_byte} << {size_index_ff, 3'b000});
   assign skip_dec    = skip_ff - 32'd1;
   assign wait_full   = {stream_byte, wait_low_ff};

   // Decode one byte against the current phase
   always_comb begin
      phase_in        = phase_ff;
      held_address_in = held_address_ff;
      wait_low_in     = wait_low_ff;
      skip_in         = skip_ff;
      size_index_in   = size_index_ff;
      stopped_in      = stopped_ff;
      result          = '0;
      result.ev.kind  = vgmcsp_pkg::EV_WRITE;

      if (byte_accept && !stopped_ff) begin
         unique case (phase_ff)
            vgmcsp_pkg::PH_WR_ADDR: begin
               if (last_byte) begin
                  stopped_in     = 1'b1;
                  phase_in       = vgmcsp_pkg::PH_CMD;
                  result.valid   = 1'b1;
                  result.ev.kind = vgmcsp_pkg::EV_TRUNC;
               end else begin
                  held_address_in = stream_byte;
                  phase_in        = vgmcsp_pkg::PH_WR_DATA;
               end
            end
            vgmcsp_pkg::PH_WR_DATA: begin
               phase_in              = vgmcsp_pkg::PH_CMD;
               result.valid          = 1'b1;
               result.ev.kind        = vgmcsp_pkg::EV_WRITE;
               result.ev.reg_address = held_address_ff;
               result.ev.reg_value   = stream_byte;
            end
            vgmcsp_pkg::PH_WAIT_LO: begin
               if (last_byte) begin
                  stopped_in     = 1'b1;
                  phase_in       = vgmcsp_pkg::PH_CMD;
                  result.valid   = 1'b1;
                  result.ev.kind = vgmcsp_pkg::EV_TRUNC;
               end else begin
                  wait_low_in = stream_byte;
                  phase_in    = vgmcsp_pkg::PH_WAIT_HI;
               end
            end
            vgmcsp_pkg::PH_WAIT_HI: begin
               // Drop a zero wait
               phase_in               = vgmcsp_pkg::PH_CMD;
               result.valid           = (wait_full != 16'd0);
               result.ev.kind         = vgmcsp_pkg::EV_WAIT;
               result.ev.wait_samples = wait_full;
            end
            vgmcsp_pkg::PH_BLK_MARK: begin
               if (last_byte) begin
                  stopped_in     = 1'b1;
                  phase_in       = vgmcsp_pkg::PH_CMD;
                  result.valid   = 1'b1;
                  result.ev.kind = vgmcsp_pkg::EV_TRUNC;
               end else begin
                  phase_in = vgmcsp_pkg::PH_BLK_TYPE;
               end
            end
            vgmcsp_pkg::PH_BLK_TYPE: begin
               if (last_byte) begin
                  stopped_in     = 1'b1;
                  phase_in       = vgmcsp_pkg::PH_CMD;
                  result.valid   = 1'b1;
                  result.ev.kind = vgmcsp_pkg::EV_TRUNC;
               end else begin
                  phase_in      = vgmcsp_pkg::PH_BLK_SIZE;
                  size_index_in = 2'd0;
                  skip_in       = 32'd0;
               end
            end
            vgmcsp_pkg::PH_BLK_SIZE: begin
               // Gather the little-endian block size
               skip_in = size_merged;
               if (size_index_ff == vgmcsp_pkg::SIZE_LAST_INDEX) begin
                  size_index_in = 2'd0;
                  if (size_merged == 32'd0) begin
                     phase_in = vgmcsp_pkg::PH_CMD;
                  end else if (last_byte) begin
                     stopped_in     = 1'b1;
                     phase_in       = vgmcsp_pkg::PH_CMD;
                     result.valid   = 1'b1;
                     result.ev.kind = vgmcsp_pkg::EV_TRUNC;
                  end else begin
                     phase_in = vgmcsp_pkg::PH_BLK_SKIP;
                  end
               end else if (last_byte) begin
                  stopped_in     = 1'b1;
                  phase_in       = vgmcsp_pkg::PH_CMD;
                  result.valid   = 1'b1;
                  result.ev.kind = vgmcsp_pkg::EV_TRUNC;
               end else begin
                  size_index_in = size_index_ff + 2'd1;
               end
            end
            vgmcsp_pkg::PH_BLK_SKIP: begin
               // Count down the block data
               skip_in = skip_dec;
               if (skip_dec == 32'd0) begin
                  phase_in = vgmcsp_pkg::PH_CMD;
               end else if (last_byte) begin
                  stopped_in     = 1'b1;
                  phase_in       = vgmcsp_pkg::PH_CMD;
                  result.valid   = 1'b1;
                  result.ev.kind = vgmcsp_pkg::EV_TRUNC;
               end
            end
            default: begin
               // Expect a command byte; unused phase codes land here too
               phase_in = vgmcsp_pkg::PH_CMD;
               priority if (stream_byte == vgmcsp_pkg::CMD_REG_WRITE ||
                            stream_byte == vgmcsp_pkg::CMD_WAIT_N ||
                            stream_byte == vgmcsp_pkg::CMD_DATA_BLOCK) begin
                  if (last_byte) begin
                     stopped_in     = 1'b1;
                     result.valid   = 1'b1;
                     result.ev.kind = vgmcsp_pkg::EV_TRUNC;
                  end else if (stream_byte == vgmcsp_pkg::CMD_REG_WRITE) begin
                     phase_in = vgmcsp_pkg::PH_WR_ADDR;
                  end else if (stream_byte == vgmcsp_pkg::CMD_WAIT_N) begin
                     phase_in = vgmcsp_pkg::PH_WAIT_LO;
                  end else begin
                     phase_in = vgmcsp_pkg::PH_BLK_MARK;
                  end
               end else if (stream_byte == vgmcsp_pkg::CMD_WAIT_NTSC) begin
                  result.valid           = 1'b1;
                  result.ev.kind         = vgmcsp_pkg::EV_WAIT;
                  result.ev.wait_samples = vgmcsp_pkg::WAIT_NTSC_SAMPLES;
               end else if (stream_byte == vgmcsp_pkg::CMD_WAIT_PAL) begin
                  result.valid           = 1'b1;
                  result.ev.kind         = vgmcsp_pkg::EV_WAIT;
                  result.ev.wait_samples = vgmcsp_pkg::WAIT_PAL_SAMPLES;
               end else if ((stream_byte & vgmcsp_pkg::CMD_SHORT_MASK) ==
                            vgmcsp_pkg::CMD_SHORT_WAIT) begin
                  result.valid           = 1'b1;
                  result.ev.kind         = vgmcsp_pkg::EV_WAIT;
                  result.ev.wait_samples =
                     {8'd0, stream_byte & vgmcsp_pkg::SHORT_LEN_MASK} + 16'd1;
               end else if (stream_byte == vgmcsp_pkg::CMD_END) begin
                  result.valid = 1'b1;
                  if (loop_enabled_ff) begin
                     result.ev.kind = vgmcsp_pkg::EV_LOOP;
                  end else begin
                     stopped_in     = 1'b1;
                     result.ev.kind = vgmcsp_pkg::EV_END;
                  end
               end else begin
                  stopped_in     = 1'b1;
                  result.valid   = 1'b1;
                  result.ev.kind = vgmcsp_pkg::EV_UNKNOWN;
               end
            end
         endcase
      end
   end

   // A stopped parser sits at the command phase
   assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> phase_ff == vgmcsp_pkg::PH_CMD)
      else $error("stopped parser left outside command phase");

   // A stopped parser emits nothing
   assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> !result.valid)
      else $error("event emitted while stopped");

   // Skipping only happens with data left to skip
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == vgmcsp_pkg::PH_BLK_SKIP |-> skip_ff != 32'd0)
      else $error("skip phase with empty count");

   // Once stopped, stay stopped until reset
   assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("parser left stopped state without reset");

endmodule

`default_nettype wire

/* sv/vgmcsp_out_buf.sv */
// Output register with a skid stage for the event channel.
`default_nettype none

module vgmcsp_out_buf (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire vgmcsp_pkg::event_beat_type result,
   output logic                          in_stall,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output vgmcsp_pkg::event_type         rsp_event
);

   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   vgmcsp_pkg::event_type out_ev_ff, out_ev_in;
   vgmcsp_pkg::event_type skid_ev_ff, skid_ev_in;
   logic                  out_free;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_stall  = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_event = out_ev_ff;

   // Steer beats into the output register or the skid stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_ev_in     = out_ev_ff;
      skid_ev_in    = skid_ev_ff;
      if (out_free) begin
         out_valid_in = 1'b0;
      end
      priority if (skid_valid_ff) begin
         if (out_free) begin
            out_valid_in  = 1'b1;
            out_ev_in     = skid_ev_ff;
            skid_valid_in = 1'b0;
         end
      end else if (result.valid) begin
         if (out_free) begin
            out_valid_in = 1'b1;
            out_ev_in    = result.ev;
         end else begin
            skid_valid_in = 1'b1;
            skid_ev_in    = result.ev;
         end
      end else begin
         skid_valid_in = 1'b0;
      end
   end

   // Hold control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      out_ev_ff  <= out_ev_in;
      skid_ev_ff <= skid_ev_in;
   end

   // Skid stage only fills behind a full output register
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid full with output register empty");

   // No new event arrives while the skid stage is full
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !result.valid)
      else $error("event arrived with skid stage full");

   // A full skid stage drains only when the output moves
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_stall |=> skid_valid_ff)
      else $error("skid beat lost under stall");

endmodule

`default_nettype wire

/* sv/vgm_command_stream_parser_unit.sv */
// Top level of the command stream parser.
// Input channel (req_): one stream byte per beat with a last-byte flag;
//   a beat is taken when req_valid is high and req_stall is low.
// Result channel (rsp_): one event per beat (register write, wait, loop
//   request, end, unknown command, truncated); rsp_stall holds the beat.
// Configuration: csr_write_enable writes csr_write_data to loop_enabled;
//   write it only while the parser is idle.
// Throughput: one byte per cycle while req_stall is low. The phase decode and
//   the 32-bit skip countdown are combinational between the parser registers
//   and the output register.
// Output: each event is registered in the output register, or in the skid
//   stage while rsp_stall holds the output. Bytes that end nothing produce no beat.
// Stall: a two-deep output (register plus skid stage) keeps taking bytes
//   while one event waits; req_stall rises once the skid stage holds an
//   event and falls the cycle after the output moves again.
// Reset (synchronous, active high): parser back to command phase, running,
//   loop_enabled cleared, both output stages emptied.
// After an end, an unknown command or a truncated command the parser stays
//   stopped and takes bytes silently until reset.
`default_nettype none

module vgm_command_stream_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_stream_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_event_kind,
   output logic [7:0]       rsp_reg_address,
   output logic [7:0]       rsp_reg_value,
   output logic [15:0]      rsp_wait_samples
);

   logic                       byte_accept;
   vgmcsp_pkg::event_beat_type result;
   vgmcsp_pkg::event_type      rsp_event;

   assign byte_accept = req_valid && !req_stall;

   // Decode bytes
   vgmcsp_decoder u_decoder (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .byte_accept      (byte_accept),
      .stream_byte      (req_stream_byte),
      .last_byte        (req_last_byte),
      .result           (result)
   );

   // Buffer events
   vgmcsp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .in_stall  (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_event (rsp_event)
   );

   assign rsp_event_kind   = rsp_event.kind;
   assign rsp_reg_address  = rsp_event.reg_address;
   assign rsp_reg_value    = rsp_event.reg_value;
   assign rsp_wait_samples = rsp_event.wait_samples;

endmodule

`default_nettype wire
